// ===== hdl/hrrb_pkg.sv =====
// ----------------------------------------------------------------------------
// hrrb_pkg
// Types, constants and defaults shared by the hop reply reorder buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package hrrb_pkg;

    // defaults for the top-level parameters
    localparam int P_MAX_HOPS = 32;
    localparam int P_QUERIES  = 3;

    // fixed limits and widths
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = 6;
    localparam int ACK_W       = 6;
    localparam logic [ACK_W-1:0] ACK_RST = 6'd8;

    localparam int HOP_OUT_W = 5;
    localparam int SLOT_W    = 72;   // {type, rtt, source}

    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 4;

    localparam logic FUNC_REPLY = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    // classified item handed from the front end to the back end
    typedef struct packed {
        logic        func;
        logic        echo;
        logic [7:0]  hop;
        logic [7:0]  msg_type;
        logic [31:0] src;
        logic [31:0] rtt;
        logic [7:0]  flush_end;    // already saturated at MAX_HOPS
    } t_cmd;

    // one result item
    typedef struct packed {
        logic [HOP_OUT_W-1:0] hop;
        logic                 lost;
        logic [31:0]          src;
        logic [7:0]           msg_type;
        logic [31:0]          rtt;
        logic                 last;
    } t_res;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_EMIT
    } t_bstate;

endpackage

`default_nettype wire

// ===== hdl/hrrb_fifo.sv =====
// ----------------------------------------------------------------------------
// hrrb_fifo
// Small flop-based FIFO with full/empty flags and a combinational head.
// ----------------------------------------------------------------------------
`default_nettype none

module hrrb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             wr_en, rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({wr_en, rd_en})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/hrrb_ram.sv =====
// ----------------------------------------------------------------------------
// hrrb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hrrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/hrrb_front.sv =====
// ----------------------------------------------------------------------------
// hrrb_front
// Front end: takes input items, computes RTT, echo flag and saturated flush end.
// ----------------------------------------------------------------------------
`default_nettype none

module hrrb_front #(
    parameter int MAX_HOPS = hrrb_pkg::P_MAX_HOPS,
    parameter int QUERIES  = hrrb_pkg::P_QUERIES
) (
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic        i_func,
    input  wire logic [7:0]  i_reply_hop,
    input  wire logic [7:0]  i_msg_type,
    input  wire logic [15:0] i_query_seq,
    input  wire logic [31:0] i_source_addr,
    input  wire logic [31:0] i_send_time,
    input  wire logic [31:0] i_arrival_time,
    input  wire logic [7:0]  i_flush_end,
    output hrrb_pkg::t_cmd   o_cmd,
    output logic             o_cmd_push,
    input  wire logic        i_cmd_full
);

    import hrrb_pkg::*;

    localparam logic [7:0]  MAX_HOPS_8 = 8'(MAX_HOPS);
    localparam logic [15:0] QUERIES_16 = 16'(QUERIES);

    logic in_range;

    assign in_range   = (i_reply_hop < MAX_HOPS_8) && (i_query_seq < QUERIES_16);
    assign o_full     = i_cmd_full;
    assign o_cmd_push = i_push;

    always_comb begin
        o_cmd.func      = i_func;
        o_cmd.echo      = (i_msg_type == 8'd0);
        o_cmd.hop       = i_reply_hop;
        o_cmd.msg_type  = i_msg_type;
        o_cmd.src       = i_source_addr;
        o_cmd.rtt       = in_range ? (i_arrival_time - i_send_time) : 32'd0;
        o_cmd.flush_end = (i_flush_end > MAX_HOPS_8) ? MAX_HOPS_8 : i_flush_end;
    end

endmodule

`default_nettype wire

// ===== hdl/hrrb_back.sv =====
// ----------------------------------------------------------------------------
// hrrb_back
// Back end: hop tracking, slot store and the in-order release walk.
// ----------------------------------------------------------------------------
`default_nettype none

module hrrb_back #(
    parameter int MAX_HOPS = hrrb_pkg::P_MAX_HOPS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [hrrb_pkg::ACK_W-1:0] i_cfg_wdata,
    input  wire hrrb_pkg::t_cmd             i_cmd,
    input  wire logic                       i_cmd_empty,
    output logic                            o_cmd_pop,
    output hrrb_pkg::t_res                  o_res,
    output logic                            o_res_push,
    input  wire logic                       i_res_full
);

    import hrrb_pkg::*;

    localparam int HW  = $clog2(MAX_HOPS);
    localparam int NHW = $clog2(MAX_HOPS + 1);
    localparam logic [NHW-1:0] MAX_N = NHW'(MAX_HOPS);
    localparam logic [8:0]     MAX_9 = 9'(MAX_HOPS);

    t_bstate        r_state, n_state;
    logic [ACK_W-1:0] r_ack;
    logic [NHW-1:0] r_next_hop, n_next_hop;
    logic [HW-1:0]  r_target_hop, n_target_hop;
    logic [NHW-1:0] r_walk_end, n_walk_end;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [MAX_HOPS-1:0] r_valid, n_valid;

    // reply/flush classification against current state
    logic           take;
    logic [7:0]     tgt_new;
    logic           drop, store, hit, trig, walk_go, flush_go;
    logic [NHW-1:0] nh1, wend, fend;
    logic [8:0]     thr9, end9;
    logic [NHW-1:0] nh_inc;
    logic           walk_last;

    logic             ram_we;
    logic [SLOT_W-1:0] ram_rdata;
    logic             slot_ok;

    assign take = (r_state == S_IDLE) && !i_cmd_empty && !i_res_full;

    always_comb begin
        tgt_new  = (i_cmd.echo && (i_cmd.hop < 8'(r_target_hop))) ? i_cmd.hop
                                                                   : 8'(r_target_hop);
        drop     = i_cmd.hop > tgt_new;
        store    = !drop && (i_cmd.hop > 8'(r_next_hop));
        hit      = !drop && (i_cmd.hop == 8'(r_next_hop));
        nh1      = r_next_hop + NHW'(hit);
        thr9     = 9'(nh1) + 9'(r_ack);
        end9     = 9'(nh1) + 9'(r_ack >> 2);
        wend     = (end9 > MAX_9) ? MAX_N : NHW'(end9);
        trig     = !drop && ({1'b0, i_cmd.hop} > thr9);
        walk_go  = trig && (nh1 < wend);
        fend     = NHW'(i_cmd.flush_end);
        flush_go = r_next_hop < fend;
    end

    // walk step
    assign nh_inc    = r_next_hop + 1'b1;
    assign walk_last = (nh_inc >= r_walk_end) || ((r_cnt + 1'b1) == CNT_W'(MAX_RESULTS));
    assign slot_ok   = r_valid[r_next_hop[HW-1:0]];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    if (i_cmd.func == FUNC_FLUSH) begin
                        if (flush_go) n_state = S_RD;
                    end else if (walk_go) begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: n_state = S_EMIT;
            S_EMIT: begin
                if (!i_res_full) n_state = walk_last ? S_IDLE : S_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_next_hop   = r_next_hop;
        n_target_hop = r_target_hop;
        n_walk_end   = r_walk_end;
        n_cnt        = r_cnt;
        n_valid      = r_valid;
        ram_we       = 1'b0;
        o_cmd_pop    = 1'b0;
        o_res_push   = 1'b0;
        o_res        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.func == FUNC_FLUSH) begin
                        n_walk_end = fend;
                        n_cnt      = '0;
                    end else begin
                        n_target_hop = HW'(tgt_new);
                        if (store) begin
                            ram_we                  = 1'b1;
                            n_valid[i_cmd.hop[HW-1:0]] = 1'b1;
                        end
                        if (hit) begin
                            n_valid[i_cmd.hop[HW-1:0]] = 1'b0;
                            o_res_push      = 1'b1;
                            o_res.hop       = i_cmd.hop[HOP_OUT_W-1:0];
                            o_res.src       = i_cmd.src;
                            o_res.msg_type  = i_cmd.msg_type;
                            o_res.rtt       = i_cmd.rtt;
                            o_res.last      = !walk_go;
                        end
                        n_next_hop = nh1;
                        n_walk_end = wend;
                        n_cnt      = CNT_W'(hit);
                    end
                end
            end
            S_RD: begin
            end
            S_EMIT: begin
                if (!i_res_full) begin
                    o_res_push      = 1'b1;
                    o_res.hop       = HOP_OUT_W'(r_next_hop);
                    o_res.lost      = !slot_ok;
                    o_res.src       = slot_ok ? ram_rdata[31:0]  : 32'd0;
                    o_res.rtt       = slot_ok ? ram_rdata[63:32] : 32'd0;
                    o_res.msg_type  = slot_ok ? ram_rdata[71:64] : 8'd0;
                    o_res.last      = walk_last;
                    n_valid[r_next_hop[HW-1:0]] = 1'b0;
                    n_next_hop = nh_inc;
                    n_cnt      = r_cnt + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ack        <= ACK_RST;
            r_next_hop   <= NHW'(1);
            r_target_hop <= HW'(MAX_HOPS - 1);
            r_walk_end   <= '0;
            r_cnt        <= '0;
            r_valid      <= '0;
        end else begin
            r_state      <= n_state;
            r_next_hop   <= n_next_hop;
            r_target_hop <= n_target_hop;
            r_walk_end   <= n_walk_end;
            r_cnt        <= n_cnt;
            r_valid      <= n_valid;
            if (i_cfg_we) begin
                r_ack <= i_cfg_wdata;
            end
        end
    end

    // read address follows next_hop; data is ready in S_EMIT, the state after S_RD
    hrrb_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_HOPS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_cmd.hop[HW-1:0]),
        .i_wdata ({i_cmd.msg_type, i_cmd.rtt, i_cmd.src}),
        .i_raddr (r_next_hop[HW-1:0]),
        .o_rdata (ram_rdata)
    );

endmodule

`default_nettype wire

// ===== hdl/hop_reply_reorder_buffer.sv =====
// ----------------------------------------------------------------------------
// hop_reply_reorder_buffer
// Releases probe replies in hop order, with loss flush and flush commands.
// ----------------------------------------------------------------------------
// A reply at the expected hop is pushed into the result queue as it is taken
//   and shows on the result side in the next cycle.
// Throughput: 1 reply per cycle when no walk follows and the result queue is not
//   full; each walked slot takes a registered slot RAM read, then an emit, and
//   no new item is taken until the walk ends.
// Reset: synchronous, active low; slot valid bits clear at once, no RAM sweep.
`default_nettype none

module hop_reply_reorder_buffer #(
    parameter int MAX_HOPS = hrrb_pkg::P_MAX_HOPS,
    parameter int QUERIES  = hrrb_pkg::P_QUERIES
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [hrrb_pkg::ACK_W-1:0] i_cfg_wdata,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic                       i_func,
    input  wire logic [7:0]                 i_reply_hop,
    input  wire logic [7:0]                 i_msg_type,
    input  wire logic [15:0]                i_query_seq,
    input  wire logic [31:0]                i_source_addr,
    input  wire logic [31:0]                i_send_time,
    input  wire logic [31:0]                i_arrival_time,
    input  wire logic [7:0]                 i_flush_end,
    output logic                            empty,
    input  wire logic                       pop,
    output logic [hrrb_pkg::HOP_OUT_W-1:0]  o_hop_out,
    output logic                            o_lost,
    output logic [31:0]                     o_src_out,
    output logic [7:0]                      o_type_out,
    output logic [31:0]                     o_rtt_us,
    output logic                            o_last
);

    import hrrb_pkg::*;

    t_cmd front_cmd, cmd_head;
    logic front_push, cmd_full, cmd_empty, cmd_pop;
    logic [$bits(t_cmd)-1:0] cmd_head_bits;
    t_res back_res, res_head;
    logic res_push, res_full;
    logic [$bits(t_res)-1:0] res_head_bits;

    hrrb_front #(
        .MAX_HOPS (MAX_HOPS),
        .QUERIES  (QUERIES)
    ) u_front (
        .i_push         (push),
        .o_full         (full),
        .i_func         (i_func),
        .i_reply_hop    (i_reply_hop),
        .i_msg_type     (i_msg_type),
        .i_query_seq    (i_query_seq),
        .i_source_addr  (i_source_addr),
        .i_send_time    (i_send_time),
        .i_arrival_time (i_arrival_time),
        .i_flush_end    (i_flush_end),
        .o_cmd          (front_cmd),
        .o_cmd_push     (front_push),
        .i_cmd_full     (cmd_full)
    );

    hrrb_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_cmd),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_head_bits),
        .o_empty (cmd_empty)
    );

    assign cmd_head = t_cmd'(cmd_head_bits);

    hrrb_back #(
        .MAX_HOPS (MAX_HOPS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd_head),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_res       (back_res),
        .o_res_push  (res_push),
        .i_res_full  (res_full)
    );

    hrrb_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_head_bits),
        .o_empty (empty)
    );

    assign res_head   = t_res'(res_head_bits);
    assign o_hop_out  = res_head.hop;
    assign o_lost     = res_head.lost;
    assign o_src_out  = res_head.src;
    assign o_type_out = res_head.msg_type;
    assign o_rtt_us   = res_head.rtt;
    assign o_last     = res_head.last;

    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result pushed into full queue");

    a_cmd_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("command popped from empty queue");

    a_lost_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_push && back_res.lost) |->
            (back_res.src == 32'd0 && back_res.msg_type == 8'd0 && back_res.rtt == 32'd0))
        else $error("lost marker carries payload");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

endmodule

`default_nettype wire

// ===== tb/hop_reply_reorder_buffer_test.sv =====
// ----------------------------------------------------------------------------
// hop_reply_reorder_buffer_test
// Drives replies and flush commands through the reorder buffer. A predictor
// tracks slots, the expected hop and the target hop, and every popped result
// is compared field by field with the oldest predicted release.
// ----------------------------------------------------------------------------
`default_nettype none

module hop_reply_reorder_buffer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hrrb_pkg::*;

    localparam int MAX_HOPS      = P_MAX_HOPS;
    localparam int QUERIES       = P_QUERIES;
    localparam int SETTLE_CYCLES = 80;
    localparam int RANDOM_ITEMS  = 320;
    localparam int ADVANCE_LIMIT = 20;   // keep hops free for the later tests
    localparam logic [7:0] TYPE_ECHO     = 8'd0;
    localparam logic [7:0] TYPE_UNREACH  = 8'd3;
    localparam logic [7:0] TYPE_TIME_EXC = 8'd11;

    typedef struct packed {
        logic        func;
        logic [7:0]  hop;
        logic [7:0]  msg_type;
        logic [15:0] seq;
        logic [31:0] src;
        logic [31:0] sent;
        logic [31:0] arrived;
        logic [7:0]  flush_end;
    } t_reply;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_cfg_we       = 1'b0;
    logic [ACK_W-1:0]  i_cfg_wdata    = '0;
    logic              push           = 1'b0;
    logic              full;
    logic              i_func         = 1'b0;
    logic [7:0]        i_reply_hop    = '0;
    logic [7:0]        i_msg_type     = '0;
    logic [15:0]       i_query_seq    = '0;
    logic [31:0]       i_source_addr  = '0;
    logic [31:0]       i_send_time    = '0;
    logic [31:0]       i_arrival_time = '0;
    logic [7:0]        i_flush_end    = '0;
    logic              empty;
    logic              pop            = 1'b0;
    logic [HOP_OUT_W-1:0] o_hop_out;
    logic              o_lost;
    logic [31:0]       o_src_out;
    logic [7:0]        o_type_out;
    logic [31:0]       o_rtt_us;
    logic              o_last;

    hop_reply_reorder_buffer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .push           (push),
        .full           (full),
        .i_func         (i_func),
        .i_reply_hop    (i_reply_hop),
        .i_msg_type     (i_msg_type),
        .i_query_seq    (i_query_seq),
        .i_source_addr  (i_source_addr),
        .i_send_time    (i_send_time),
        .i_arrival_time (i_arrival_time),
        .i_flush_end    (i_flush_end),
        .empty          (empty),
        .pop            (pop),
        .o_hop_out      (o_hop_out),
        .o_lost         (o_lost),
        .o_src_out      (o_src_out),
        .o_type_out     (o_type_out),
        .o_rtt_us       (o_rtt_us),
        .o_last         (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic             slot_full [MAX_HOPS];
    logic [31:0]      slot_src  [MAX_HOPS];
    logic [7:0]       slot_type [MAX_HOPS];
    logic [31:0]      slot_rtt  [MAX_HOPS];
    int               next_hop   = 1;
    int               target_hop = MAX_HOPS - 1;
    logic [ACK_W-1:0] ack_window = ACK_RST;

    t_res expected_releases [$];
    t_res held_release;
    logic have_held;
    int   release_count;

    int   errors  = 0;
    logic calm    = 1'b0;
    int   rx_gap  = 0;
    int   rx_hold = 0;
    t_res want;

    // a release is held back one step so the final one can carry last
    task automatic stage_release(input int hop, input logic lost, input logic [31:0] src,
                                 input logic [7:0] ty, input logic [31:0] rtt);
        if (have_held)
            expected_releases.push_back(held_release);
        held_release.hop       = hop[HOP_OUT_W-1:0];
        held_release.lost      = lost;
        held_release.src       = src;
        held_release.msg_type  = ty;
        held_release.rtt       = rtt;
        held_release.last      = 1'b0;
        have_held = 1'b1;
        release_count++;
    endtask

    task automatic walk_slots(input int end_hop);
        if (end_hop > MAX_HOPS)
            end_hop = MAX_HOPS;
        while (next_hop < end_hop && release_count < MAX_RESULTS) begin
            if (slot_full[next_hop]) begin
                stage_release(next_hop, 1'b0, slot_src[next_hop], slot_type[next_hop],
                              slot_rtt[next_hop]);
                slot_full[next_hop] = 1'b0;
            end else begin
                stage_release(next_hop, 1'b1, '0, '0, '0);
            end
            next_hop++;
        end
    endtask

    task automatic predict_release(input t_reply it);
        int          hop;
        logic [31:0] rtt;
        hop = int'(it.hop);
        rtt = '0;
        release_count = 0;
        have_held = 1'b0;
        if (it.func == FUNC_FLUSH) begin
            walk_slots(int'(it.flush_end));
        end else begin
            if (hop < MAX_HOPS && it.seq < QUERIES)
                rtt = it.arrived - it.sent;
            if (it.msg_type == TYPE_ECHO && hop < target_hop)
                target_hop = hop;
            if (hop <= target_hop) begin
                if (hop > next_hop) begin
                    slot_full[hop] = 1'b1;
                    slot_src[hop]  = it.src;
                    slot_type[hop] = it.msg_type;
                    slot_rtt[hop]  = rtt;
                end else if (hop == next_hop) begin
                    stage_release(hop, 1'b0, it.src, it.msg_type, rtt);
                    slot_full[hop] = 1'b0;
                    next_hop++;
                end
                if (hop > next_hop + ack_window && hop < MAX_HOPS)
                    walk_slots(next_hop + ack_window / 4);
            end
        end
        if (have_held) begin
            held_release.last = 1'b1;
            expected_releases.push_back(held_release);
        end
    endtask

    function automatic t_reply make_reply(input logic [7:0] hop, input logic [7:0] ty,
                                          input logic [15:0] seq, input logic [31:0] src,
                                          input logic [31:0] sent, input logic [31:0] arrived);
        t_reply it;
        it.func      = FUNC_REPLY;
        it.hop       = hop;
        it.msg_type  = ty;
        it.seq       = seq;
        it.src       = src;
        it.sent      = sent;
        it.arrived   = arrived;
        it.flush_end = 8'($urandom);
        return it;
    endfunction

    function automatic t_reply make_flush(input logic [7:0] end_hop);
        t_reply it;
        it           = make_reply(8'($urandom), 8'($urandom), 16'($urandom), $urandom,
                                  $urandom, $urandom);
        it.func      = FUNC_FLUSH;
        it.flush_end = end_hop;
        return it;
    endfunction

    task automatic send_item(input t_reply it);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            push = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        i_func         = it.func;
        i_reply_hop    = it.hop;
        i_msg_type     = it.msg_type;
        i_query_seq    = it.seq;
        i_source_addr  = it.src;
        i_send_time    = it.sent;
        i_arrival_time = it.arrived;
        i_flush_end    = it.flush_end;
        push           = 1'b1;
        do @(posedge i_clk); while (full);
        predict_release(it);
    endtask

    task automatic wait_drained(input int settle);
        @(negedge i_clk);
        push = 1'b0;
        while (expected_releases.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [ACK_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        ack_window  = value;
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
                     exp_val, act_val);
            errors++;
        end
    endtask

    // receiver: random pop gaps, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            pop = 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            pop = 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            rx_gap = int'($urandom_range(0, 15));
            pop = 1'b0;
        end else begin
            pop = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (expected_releases.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual hop %0d lost %0b",
                         $time, o_hop_out, o_lost);
                errors++;
            end else begin
                want = expected_releases.pop_front();
                check_field("hop_out",  32'(want.hop),      32'(o_hop_out));
                check_field("lost",     32'(want.lost),     32'(o_lost));
                check_field("src_out",  want.src,           o_src_out);
                check_field("type_out", 32'(want.msg_type), 32'(o_type_out));
                check_field("rtt_us",   want.rtt,           o_rtt_us);
                check_field("last",     32'(want.last),     32'(o_last));
            end
        end
    end

    task automatic test_in_order_release();
        send_item(make_reply(1, TYPE_TIME_EXC, 0, 32'hC0A8_0001, 32'd100, 32'd350));
        send_item(make_reply(3, TYPE_UNREACH, 5, 32'h0A00_0003, 32'd10, 32'd99));
        // repeated hop replaces the stored one; rtt wraps
        send_item(make_reply(3, TYPE_TIME_EXC, 2, 32'h0A00_0033, 32'hFFFF_FFF0, 32'h10));
        send_item(make_reply(2, TYPE_TIME_EXC, 16'hFFFF, 32'h0A00_0002, 32'd5, 32'd9));
        // expected hop while its slot holds an entry
        send_item(make_reply(3, TYPE_UNREACH, 1, 32'h0A00_0303, 32'd0, 32'hFFFF_FFFF));
        send_item(make_reply(1, TYPE_TIME_EXC, 0, 32'h1111_1111, 32'd1, 32'd2));
        send_item(make_reply(0, TYPE_TIME_EXC, 0, 32'h0, 32'd0, 32'd0));
        send_item(make_reply(255, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF));
        send_item(make_reply(8'(MAX_HOPS), TYPE_TIME_EXC, 0, 32'h2222_2222, 32'd3, 32'd7));
        send_item(make_flush(8'(next_hop)));
        send_item(make_flush(0));
        send_item(make_reply(8'(next_hop + 1), TYPE_TIME_EXC, 1, 32'hAC10_0005, 32'd40,
                             32'd1040));
        send_item(make_flush(8'(next_hop + 3)));
        // hop past the window: loss flush up to next_hop + window/4
        send_item(make_reply(8'(next_hop + ack_window + 1), TYPE_UNREACH, 0, 32'hAC10_0010,
                             32'd7, 32'd77));
    endtask

    task automatic test_window_register();
        wait_drained(SETTLE_CYCLES);
        write_window(6'd0);
        send_item(make_reply(8'(next_hop + 2), TYPE_TIME_EXC, 0, 32'h5555_0001, 32'd1,
                             32'd9));
        wait_drained(SETTLE_CYCLES);
        write_window(6'd4);
        send_item(make_reply(8'(next_hop + 6), TYPE_TIME_EXC, 2, 32'h5555_0002, 32'd2,
                             32'd8));
        wait_drained(SETTLE_CYCLES);
        write_window(6'd32);
        send_item(make_reply(8'(MAX_HOPS - 1), TYPE_UNREACH, 1, 32'h5555_0003, 32'd3,
                             32'd33));
        wait_drained(SETTLE_CYCLES);
        write_window(6'd63);
        send_item(make_reply(8'(next_hop + 1), TYPE_TIME_EXC, 0, 32'h5555_0004, 32'd4,
                             32'd44));
    endtask

    task automatic test_random_reordering();
        t_reply it;
        int     pick;
        wait_drained(SETTLE_CYCLES);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            it = make_reply(8'($urandom_range(0, 255)), 8'($urandom_range(1, 255)),
                            16'($urandom), $urandom, $urandom, $urandom);
            if (pick < 4 && next_hop < ADVANCE_LIMIT) begin
                it.hop = 8'(next_hop);
            end else if (pick < 7 && next_hop < ADVANCE_LIMIT) begin
                it = make_flush(8'(next_hop + $urandom_range(1, 2)));
            end else if (pick < 80) begin
                if (next_hop < MAX_HOPS - 1)
                    it.hop = 8'($urandom_range(next_hop + 1, MAX_HOPS - 1));
                if ($urandom_range(0, 3) != 0)
                    it.seq = 16'($urandom_range(0, QUERIES));
            end else if (pick < 90) begin
                it = make_flush(8'($urandom_range(0, next_hop)));
            end
            send_item(it);
        end
    endtask

    task automatic test_echo_target();
        int echo_hop;
        wait_drained(SETTLE_CYCLES);
        echo_hop = next_hop + 3;
        if (echo_hop > MAX_HOPS - 3)
            echo_hop = MAX_HOPS - 3;
        send_item(make_reply(8'(echo_hop), TYPE_ECHO, 1, 32'h0808_0808, 32'd500, 32'd900));
        send_item(make_reply(8'(echo_hop + 2), TYPE_TIME_EXC, 0, 32'h0909_0909, 32'd1,
                             32'd5));
        send_item(make_reply(8'(echo_hop), TYPE_ECHO, 0, 32'h0808_0404, 32'd600, 32'd610));
        send_item(make_reply(8'(echo_hop - 1), TYPE_UNREACH, 2, 32'h0707_0707, 32'd20,
                             32'd25));
    endtask

    task automatic test_backpressure();
        wait_drained(SETTLE_CYCLES);
        calm = 1'b1;
        rx_hold = 400;
        // saturating flush releases every remaining hop while pop is held off
        send_item(make_flush(8'hFF));
        for (int n = 0; n < 10; n++) begin
            if (n % 2 == 0)
                send_item(make_flush(8'($urandom_range(0, MAX_HOPS))));
            else
                send_item(make_reply(8'($urandom_range(0, MAX_HOPS - 1)), TYPE_TIME_EXC,
                                     16'($urandom), $urandom, $urandom, $urandom));
        end
    endtask

    initial begin
        foreach (slot_full[h])
            slot_full[h] = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_in_order_release();
        test_window_register();
        test_random_reordering();
        test_echo_target();
        test_backpressure();
        wait_drained(SETTLE_CYCLES);
        if (errors == 0)
            $display("[hop_reply_reorder_buffer] OK");
        else
            $display("[hop_reply_reorder_buffer] ERROR");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("[hop_reply_reorder_buffer] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
